/* rtl/bpra_pkg.sv */
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared codes, field widths and controller/datapath interface structs for
// the bitmap page run allocator.
// ----------------------------------------------------------------------------
package bpra_pkg;

   // payload field widths
   localparam int REQ_TYPE_W     = 1;
   localparam int ALLOC_BYTES_W  = 30;
   localparam int FREE_ADDR_W    = 29;
   localparam int STATUS_W       = 2;
   localparam int BLOCK_ADDR_W   = 29;
   localparam int FIRST_PAGE_W   = 10;
   localparam int PAGE_COUNT_W   = 11;
   localparam int ACTIVE_PAGES_W = 11;

   // width of byte size / address arithmetic (one carry bit above the size)
   localparam int SUM_W = ALLOC_BYTES_W + 1;

   localparam logic [ACTIVE_PAGES_W-1:0] ACTIVE_PAGES_RESET = 11'd1024;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic                load;           // latch request word
      logic                scan_start;     // reset scan pointer and run
      logic                scan_step;      // one bitmap page per cycle
      logic                span_from_scan; // hit: set up mark span, record run
      logic                span_from_free; // start found: set up clear span
      logic                span_step;      // write one page of the span
      logic                span_set;       // 1 mark used, 0 clear
      logic                free_read;      // look up start page of a free
      logic                res_load;       // load result register
      logic [STATUS_W-1:0] res_code;
   } bpra_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_free;
      logic zero_bytes;
      logic too_big;
      logic misaligned;
      logic out_of_range;
      logic addr_zero;
      logic scan_hit;
      logic scan_end;
      logic span_last;
      logic start_bit;
      logic rsp_free;
   } bpra_stat_type;

endpackage

/* rtl/bpra_ram.sv */
// ----------------------------------------------------------------------------
// bpra_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bpra_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bpra_dp.sv */
// ----------------------------------------------------------------------------
// bpra_dp
// Datapath: request latch, bitmap scan pointer and run counter, span writer,
// page state and run length RAMs, result register.
// ----------------------------------------------------------------------------
module bpra_dp #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_SHIFT = 19
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bpra_pkg::bpra_cmd_type                cmd,
   output bpra_pkg::bpra_stat_type               stat,
   input  logic [bpra_pkg::REQ_TYPE_W-1:0]       req_type,
   input  logic [bpra_pkg::ALLOC_BYTES_W-1:0]    req_alloc_bytes,
   input  logic [bpra_pkg::FREE_ADDR_W-1:0]      req_free_address,
   input  logic [bpra_pkg::ACTIVE_PAGES_W-1:0]   active_pages,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bpra_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bpra_pkg::BLOCK_ADDR_W-1:0]     rsp_block_address,
   output logic [bpra_pkg::FIRST_PAGE_W-1:0]     rsp_first_page,
   output logic [bpra_pkg::PAGE_COUNT_W-1:0]     rsp_page_count
);
   import bpra_pkg::*;

   localparam int PAGE_W  = $clog2(NUM_PAGES);
   localparam int CNT_W   = $clog2(NUM_PAGES + 1);
   localparam int NEED_W  = SUM_W - PAGE_SHIFT;
   localparam int ADDR_XW = PAGE_W + PAGE_SHIFT;
   localparam logic [SUM_W-1:0] PAGE_MASK = (SUM_W'(1) << PAGE_SHIFT) - SUM_W'(1);

   // latched request
   logic [REQ_TYPE_W-1:0] type_ff, type_in;
   logic                  zero_ff, zero_in;
   logic [NEED_W-1:0]     need_ff, need_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic                  misal_ff, misal_in;
   logic                  oob_ff, oob_in;
   logic                  addrz_ff, addrz_in;
   // scan
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic                  dv_ff, dv_in;
   logic [CNT_W-1:0]      dpage_ff, dpage_in;
   logic [CNT_W-1:0]      run_ff, run_in;
   // span / block
   logic [PAGE_W-1:0]     start_ff, start_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PAGE_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PAGE_W-1:0]     wr_end_ff, wr_end_in;
   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [BLOCK_ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [FIRST_PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [PAGE_COUNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic [SUM_W-1:0]  bytes_sum;
   logic [SUM_W-1:0]  addr_x;
   logic [SUM_W-1:0]  page_x;
   logic              rd_scan;
   logic              used_bit;
   logic              hit;
   logic [CNT_W-1:0]  start_c;
   logic [CNT_W-1:0]  free_end_c;

   // RAM ports
   logic              st_wr_en;
   logic [1:0]        st_wr_data;
   logic              st_rd_en;
   logic [PAGE_W-1:0] st_rd_addr;
   logic [1:0]        st_rd_data;
   logic              run_wr_en;
   logic [CNT_W-1:0]  run_rd_data;

   // page state word: [1] used, [0] block starts here
   bpra_ram #(.WIDTH(2), .DEPTH(NUM_PAGES)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // run length per start page, used only where the start bit is set
   bpra_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_run_ram (
      .clock   (clock),
      .wr_en   (run_wr_en),
      .wr_addr (start_c[PAGE_W-1:0]),
      .wr_data (CNT_W'(need_ff)),
      .rd_en   (cmd.free_read),
      .rd_addr (page_ff),
      .rd_data (run_rd_data)
   );

   assign bytes_sum  = SUM_W'(req_alloc_bytes) + PAGE_MASK;
   assign addr_x     = SUM_W'(req_free_address);
   assign page_x     = addr_x >> PAGE_SHIFT;
   assign rd_scan    = ptr_ff < limit_ff;
   assign used_bit   = st_rd_data[1];
   assign hit        = dv_ff && !used_bit && (32'(run_ff) + 32'd1 == 32'(need_ff));
   assign start_c    = dpage_ff + CNT_W'(1) - CNT_W'(need_ff);
   assign free_end_c = CNT_W'(page_ff) + run_rd_data - CNT_W'(1);

   assign st_rd_en   = cmd.free_read || (cmd.scan_step && rd_scan);
   assign st_rd_addr = cmd.free_read ? page_ff : ptr_ff[PAGE_W-1:0];
   assign st_wr_en   = cmd.span_step;
   assign st_wr_data = cmd.span_set ? {1'b1, wr_ptr_ff == start_ff} : 2'b00;
   assign run_wr_en  = cmd.span_from_scan;

   always_comb begin
      type_in       = type_ff;
      zero_in       = zero_ff;
      need_in       = need_ff;
      limit_in      = limit_ff;
      page_in       = page_ff;
      misal_in      = misal_ff;
      oob_in        = oob_ff;
      addrz_in      = addrz_ff;
      ptr_in        = ptr_ff;
      dv_in         = dv_ff;
      dpage_in      = dpage_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      cnt_in        = cnt_ff;
      wr_ptr_in     = wr_ptr_ff;
      wr_end_in     = wr_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      if (cmd.load) begin
         type_in  = req_type;
         zero_in  = req_alloc_bytes == '0;
         need_in  = bytes_sum[SUM_W-1:PAGE_SHIFT];
         misal_in = (addr_x & PAGE_MASK) != '0;
         oob_in   = 32'(page_x) >= 32'(NUM_PAGES);
         page_in  = page_x[PAGE_W-1:0];
         addrz_in = req_free_address == '0;
         if (32'(active_pages) > 32'(NUM_PAGES)) begin
            limit_in = CNT_W'(NUM_PAGES);
         end else begin
            limit_in = CNT_W'(active_pages);
         end
      end

      if (cmd.scan_start) begin
         ptr_in = '0;
         dv_in  = 1'b0;
         run_in = '0;
      end

      if (cmd.scan_step) begin
         if (rd_scan) begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
         dv_in    = rd_scan;
         dpage_in = ptr_ff;
         if (dv_ff) begin
            run_in = used_bit ? '0 : run_ff + CNT_W'(1);
         end
      end

      if (cmd.span_from_scan) begin
         start_in  = start_c[PAGE_W-1:0];
         cnt_in    = CNT_W'(need_ff);
         wr_ptr_in = start_c[PAGE_W-1:0];
         wr_end_in = dpage_ff[PAGE_W-1:0];
      end

      if (cmd.span_from_free) begin
         start_in  = page_ff;
         cnt_in    = run_rd_data;
         wr_ptr_in = page_ff;
         wr_end_in = free_end_c[PAGE_W-1:0];
      end

      if (cmd.span_step) begin
         wr_ptr_in = wr_ptr_ff + PAGE_W'(1);
      end

      if (cmd.res_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.res_code;
         if (cmd.res_code == ST_DONE) begin
            rsp_addr_in = BLOCK_ADDR_W'(ADDR_XW'(start_ff) << PAGE_SHIFT);
            rsp_page_in = FIRST_PAGE_W'(start_ff);
            rsp_cnt_in  = PAGE_COUNT_W'(cnt_ff);
         end else begin
            rsp_addr_in = '0;
            rsp_page_in = '0;
            rsp_cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         dv_ff        <= 1'b0;
         run_ff       <= '0;
         wr_ptr_ff    <= '0;
         wr_end_ff    <= PAGE_W'(NUM_PAGES - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         dv_ff        <= dv_in;
         run_ff       <= run_in;
         wr_ptr_ff    <= wr_ptr_in;
         wr_end_ff    <= wr_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff       <= type_in;
      zero_ff       <= zero_in;
      need_ff       <= need_in;
      limit_ff      <= limit_in;
      page_ff       <= page_in;
      misal_ff      <= misal_in;
      oob_ff        <= oob_in;
      addrz_ff      <= addrz_in;
      dpage_ff      <= dpage_in;
      start_ff      <= start_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign stat.is_free      = type_ff == REQ_FREE;
   assign stat.zero_bytes   = zero_ff;
   assign stat.too_big      = 32'(need_ff) > 32'(limit_ff);
   assign stat.misaligned   = misal_ff;
   assign stat.out_of_range = oob_ff;
   assign stat.addr_zero    = addrz_ff;
   assign stat.scan_hit     = hit;
   assign stat.scan_end     = dv_ff && !hit && (32'(dpage_ff) + 32'd1 == 32'(limit_ff));
   assign stat.span_last    = wr_ptr_ff == wr_end_ff;
   assign stat.start_bit    = st_rd_data[0];
   assign stat.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_first_page    = rsp_page_ff;
   assign rsp_page_count    = rsp_cnt_ff;

endmodule

/* rtl/bpra_ctrl.sv */
// ----------------------------------------------------------------------------
// bpra_ctrl
// Controller: clearing pass, request decode, scan, mark/clear spans and
// result hand-off.
// ----------------------------------------------------------------------------
module bpra_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bpra_pkg::bpra_stat_type stat,
   output bpra_pkg::bpra_cmd_type  cmd
);
   import bpra_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_MARK   = 3'd4;
   localparam logic [2:0] S_FCHK   = 3'd5;
   localparam logic [2:0] S_FCLR   = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic [STATUS_W-1:0] miss_code;

   // unknown page: address zero reads as a null free
   assign miss_code = stat.addr_zero ? ST_NULL : ST_UNKNOWN;

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.span_step = 1'b1;
            if (stat.span_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!stat.is_free) begin
               if (stat.zero_bytes) begin
                  code_in  = ST_NULL;
                  state_in = S_OUT;
               end else if (stat.too_big) begin
                  code_in  = ST_NOSPACE;
                  state_in = S_OUT;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end else if (stat.misaligned) begin
               code_in  = ST_UNKNOWN;
               state_in = S_OUT;
            end else if (stat.out_of_range) begin
               code_in  = miss_code;
               state_in = S_OUT;
            end else begin
               cmd.free_read = 1'b1;
               state_in      = S_FCHK;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               cmd.span_from_scan = 1'b1;
               state_in           = S_MARK;
            end else if (stat.scan_end) begin
               code_in  = ST_NOSPACE;
               state_in = S_OUT;
            end
         end
         S_MARK: begin
            cmd.span_step = 1'b1;
            cmd.span_set  = 1'b1;
            if (stat.span_last) begin
               code_in  = ST_DONE;
               state_in = S_OUT;
            end
         end
         S_FCHK: begin
            if (stat.start_bit) begin
               cmd.span_from_free = 1'b1;
               state_in           = S_FCLR;
            end else begin
               code_in  = miss_code;
               state_in = S_OUT;
            end
         end
         S_FCLR: begin
            cmd.span_step = 1'b1;
            if (stat.span_last) begin
               code_in  = ST_DONE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.rsp_free) begin
               cmd.res_load = 1'b1;
               cmd.res_code = code_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

/* rtl/bitmap_page_run_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// First-fit contiguous page allocator over a used-page bitmap. Allocate
// rounds a byte size up to whole pages and takes the lowest free run below
// the active page count; free releases a block by its start address.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid/req_ready   | type, alloc bytes, free address
//  rsp     | out       | rsp_valid/rsp_ready   | status, address, page, count
//  csr     | in        | csr_valid/csr_ready   | active page count (always ready)
//
//  One request at a time. Allocate: scans pages, then marks the run pages;
//  the one-page-per-cycle bitmap scan dominates. Free: clears the block
//  pages. Rejected at decode: no scan or span write. Free of a page with no
//  block: start lookup only. Failed scan: covers the active pages (clipped to NUM_PAGES).
//  Reset: clearing pass over all NUM_PAGES pages, req_ready low, csr writes taken.
//  Stalls: a held rsp_ready parks one finished word; the next stops in turn.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_SHIFT = 19
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bpra_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [bpra_pkg::ALLOC_BYTES_W-1:0]  req_alloc_bytes,
   input  logic [bpra_pkg::FREE_ADDR_W-1:0]    req_free_address,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bpra_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bpra_pkg::BLOCK_ADDR_W-1:0]   rsp_block_address,
   output logic [bpra_pkg::FIRST_PAGE_W-1:0]   rsp_first_page,
   output logic [bpra_pkg::PAGE_COUNT_W-1:0]   rsp_page_count,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpra_pkg::ACTIVE_PAGES_W-1:0] csr_active_pages
);
   import bpra_pkg::*;

   logic [ACTIVE_PAGES_W-1:0] active_pages_ff, active_pages_in;
   bpra_cmd_type              cmd;
   bpra_stat_type             stat;

   // active page count; values above NUM_PAGES are clipped when a request is loaded
   assign csr_ready       = 1'b1;
   assign active_pages_in = (csr_valid && csr_ready) ? csr_active_pages : active_pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_pages_ff <= ACTIVE_PAGES_RESET;
      end else begin
         active_pages_ff <= active_pages_in;
      end
   end

   // sequencing: clear pass, decode, scan, span writes, result hand-off
   bpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bitmap, run lengths, scan and result register
   bpra_dp #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_alloc_bytes   (req_alloc_bytes),
      .req_free_address  (req_free_address),
      .active_pages      (active_pages_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_first_page    (rsp_first_page),
      .rsp_page_count    (rsp_page_count)
   );

endmodule
